// File: rtl/lsps_pkg.sv
// Shared types and constants of the LED strip pixel shader.
// No dependencies; every other file of the block imports it.
package lsps_pkg;

    // Effect modes held in the mode register
    localparam logic [1:0] MODE_GENTLE = 2'd0;
    localparam logic [1:0] MODE_RIPPLE = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [1:0] REG_MAX_RED     = 2'd1;
    localparam logic [1:0] REG_MAX_GREEN   = 2'd2;
    localparam logic [1:0] REG_MAX_BLUE    = 2'd3;

    // Pixel offset to angle, Q8 scale factors for 1/80 rad and 1/30 rad
    localparam logic [16:0] GENTLE_K    = 17'd33377;
    localparam logic [16:0] RIPPLE_K    = 17'd89006;
    // 0.001 rad as a 32-bit binary angle
    localparam logic [31:0] BREATH_STEP = 32'd683565;

    // Ripple amplitude: floor(16384*e/180) = (e * AMP_RECIP) >> 14 for e <= 180
    localparam logic [20:0] AMP_RECIP   = 21'd1491309;
    localparam logic [7:0]  ENERGY_CAP  = 8'd180;

    // Gain offsets and sine coefficients, Q1.15
    localparam logic [15:0] GENTLE_BASE = 16'd32768;
    localparam logic [14:0] GENTLE_COEF = 15'd5898;
    localparam logic [15:0] RIPPLE_BASE = 16'd27853;
    localparam logic [14:0] RIPPLE_AMP0 = 15'd4915;
    localparam logic [15:0] BREATH_BASE = 16'd31130;
    localparam logic [14:0] BREATH_COEF = 15'd1638;

    // Quarter-wave polynomial constants
    localparam logic [15:0] POLY_C0 = 16'd51472;
    localparam logic [14:0] POLY_C1 = 15'd21024;
    localparam logic [11:0] POLY_C2 = 12'd2320;
    localparam logic [15:0] QUARTER = 16'd32768;
    localparam logic [14:0] P_MAX   = 15'd32767;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified pixel job between front and back
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] angle;
        logic [7:0]  energy;
        logic [7:0]  base_red;
        logic [7:0]  base_green;
        logic [7:0]  base_blue;
        logic [7:0]  brightness;
        logic [7:0]  index;
    } t_job;

    // Channel saturation limits
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_limits;

endpackage

// File: rtl/lsps_front.sv
// Front end: accepts pixel requests, keeps the breath angle and forms the sine angle.
// Depends on lsps_pkg.
module lsps_front
    import lsps_pkg::*;
#(
    parameter int LED_COUNT       = 256,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_pixel_index,
    input  logic        i_frame_start,
    input  logic [15:0] i_phase_angle,
    input  logic [9:0]  i_motion_energy,
    input  logic [7:0]  i_base_red,
    input  logic [7:0]  i_base_green,
    input  logic [7:0]  i_base_blue,
    input  logic [7:0]  i_brightness_in,
    input  logic        i_space,
    output logic        o_push,
    output t_job        o_job
);

    localparam int HALF  = LED_COUNT / 2;
    localparam int MAG_W = $clog2(((HALF > 255) ? HALF : 255) + 1);
    localparam int PW    = MAG_W + 17;
    localparam logic [MAG_W-1:0] HALF_V = MAG_W'(HALF);
    localparam int DROP = 16 - SINE_TABLE_BITS;
    localparam logic [15:0] ANG_MASK = 16'hFFFF << DROP;

    logic [31:0]      r_breath;
    logic [31:0]      n_breath;
    logic [MAG_W-1:0] idx_w;
    logic [MAG_W-1:0] mag;
    logic             below;
    logic [16:0]      k;
    logic [PW-1:0]    off_prod;
    logic [15:0]      off_ang;
    logic [15:0]      ang;

    assign o_ready = i_space;
    assign o_push  = i_valid && i_space;

    always_comb begin
        idx_w    = MAG_W'(i_pixel_index);
        below    = idx_w < HALF_V;
        mag      = below ? (HALF_V - idx_w) : (idx_w - HALF_V);
        k        = (i_mode == MODE_RIPPLE) ? RIPPLE_K : GENTLE_K;
        off_prod = PW'(mag) * PW'(k);
        off_ang  = off_prod[23:8];

        n_breath = r_breath;
        if (i_mode == MODE_BREATH && i_frame_start) begin
            n_breath = r_breath + BREATH_STEP;
        end

        unique case (i_mode)
            MODE_GENTLE: ang = (below ? (16'd0 - off_ang) : off_ang) + i_phase_angle;
            MODE_RIPPLE: ang = off_ang - i_phase_angle;
            MODE_BREATH: ang = n_breath[31:16];
            default:     ang = 16'd0;
        endcase

        o_job.mode       = i_mode;
        o_job.angle      = ang & ANG_MASK;
        o_job.energy     = (i_motion_energy > 10'(ENERGY_CAP)) ? ENERGY_CAP
                                                               : i_motion_energy[7:0];
        o_job.base_red   = i_base_red;
        o_job.base_green = i_base_green;
        o_job.base_blue  = i_base_blue;
        o_job.brightness = i_brightness_in;
        o_job.index      = i_pixel_index;
    end

    // Advance the breath angle only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breath <= 32'd0;
        end else if (o_push) begin
            r_breath <= n_breath;
        end
    end

endmodule

// File: rtl/lsps_queue.sv
// Short job queue between front and back end.
// Depends on lsps_pkg.
module lsps_queue
    import lsps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_space,
    input  logic i_pop,
    output logic o_avail,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_space = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_avail = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_space))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_avail))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a write");

endmodule

// File: rtl/lsps_back.sv
// Back end: sine polynomial, gain and channel scaling on one shared multiplier,
// with the output register. Depends on lsps_pkg.
module lsps_back
    import lsps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_avail,
    input  t_job       i_job,
    output logic       o_pop,
    input  t_limits    i_limits,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixel_out_index,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_brightness
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AMP   = 4'd1;
    localparam logic [3:0] ST_X2    = 4'd2;
    localparam logic [3:0] ST_INNER = 4'd3;
    localparam logic [3:0] ST_RPOLY = 4'd4;
    localparam logic [3:0] ST_POLY  = 4'd5;
    localparam logic [3:0] ST_GAIN  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_MR    = 4'd8;
    localparam logic [3:0] ST_MG    = 4'd9;
    localparam logic [3:0] ST_MB    = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    t_job                r_job;
    logic [15:0]         r_x;
    logic                r_neg;
    logic [14:0]         r_coef;
    logic [15:0]         r_base;
    logic [15:0]         r_x2;
    logic [15:0]         r_gain;
    logic [7:0]          r_red;
    logic [7:0]          r_green;
    logic signed [40:0]  r_prod;
    logic                r_valid;
    logic [7:0]          r_idx_o;
    logic [7:0]          r_red_o;
    logic [7:0]          r_green_o;
    logic [7:0]          r_blue_o;
    logic [7:0]          r_bright_o;

    logic signed [22:0]  m_a;
    logic signed [17:0]  m_b;
    logic [15:0]         x_new;
    logic [14:0]         inner;
    logic [15:0]         rpoly;
    logic [14:0]         p_val;
    logic signed [17:0]  s_val;
    logic signed [40:0]  biased;
    logic [15:0]         gain;
    logic [8:0]          chan;
    logic [7:0]          chan_limit;
    logic [7:0]          chan_sat;
    logic                out_free;
    logic                off;

    assign o_pop    = (r_state == ST_IDLE) && i_avail;
    assign out_free = !r_valid || i_ready;
    assign off      = r_job.mode == MODE_OFF;

    always_comb begin
        x_new = {1'b0, i_job.angle[13:0], 1'b0};
        if (i_job.angle[14]) begin
            x_new = QUARTER - x_new;
        end
        inner = POLY_C1 - r_prod[29:15];
        rpoly = POLY_C0 - r_prod[30:15];
        p_val = (r_prod[31:15] > {2'b00, P_MAX}) ? P_MAX : r_prod[29:15];
        s_val = r_neg ? -$signed({3'b000, p_val}) : $signed({3'b000, p_val});
        biased = r_prod + ((r_prod < 0) ? 41'sd32767 : 41'sd0);
        gain   = r_base + biased[30:15];

        chan = r_prod[23:15];
        unique case (r_state)
            ST_MG:   chan_limit = i_limits.red;
            ST_MB:   chan_limit = i_limits.green;
            default: chan_limit = i_limits.blue;
        endcase
        chan_sat = (chan > {1'b0, chan_limit}) ? chan_limit : chan[7:0];
    end

    // Shared multiplier operand selection
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_AMP: begin
                m_a = 23'(AMP_RECIP);
                m_b = 18'(r_job.energy);
            end
            ST_X2: begin
                m_a = 23'(r_x);
                m_b = 18'(r_x);
            end
            ST_INNER: begin
                m_a = 23'(r_prod[30:15]);
                m_b = 18'(POLY_C2);
            end
            ST_RPOLY: begin
                m_a = 23'(inner);
                m_b = 18'(r_x2);
            end
            ST_POLY: begin
                m_a = 23'(rpoly);
                m_b = 18'(r_x);
            end
            ST_GAIN: begin
                m_a = 23'(r_coef);
                m_b = s_val;
            end
            ST_MR: begin
                m_a = 23'(r_gain);
                m_b = 18'(r_job.base_red);
            end
            ST_MG: begin
                m_a = 23'(r_gain);
                m_b = 18'(r_job.base_green);
            end
            ST_MB, ST_OUT: begin
                m_a = 23'(r_gain);
                m_b = 18'(r_job.base_blue);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    unique case (i_job.mode)
                        MODE_OFF:    n_state = ST_OUT;
                        MODE_RIPPLE: n_state = ST_AMP;
                        default:     n_state = ST_X2;
                    endcase
                end
            end
            ST_AMP:   n_state = ST_X2;
            ST_X2:    n_state = ST_INNER;
            ST_INNER: n_state = ST_RPOLY;
            ST_RPOLY: n_state = ST_POLY;
            ST_POLY:  n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_MR;
            ST_MR:    n_state = ST_MG;
            ST_MG:    n_state = ST_MB;
            ST_MB:    n_state = ST_OUT;
            ST_OUT:   n_state = out_free ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Hold the blue product while the result waits for the output register
        if (r_state != ST_OUT) begin
            r_prod <= m_a * m_b;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    r_job <= i_job;
                    r_x   <= x_new;
                    r_neg <= i_job.angle[15];
                    if (i_job.mode == MODE_BREATH) begin
                        r_coef <= BREATH_COEF;
                        r_base <= BREATH_BASE;
                    end else begin
                        r_coef <= GENTLE_COEF;
                        r_base <= GENTLE_BASE;
                    end
                end
            end
            ST_X2: begin
                if (r_job.mode == MODE_RIPPLE) begin
                    r_coef <= RIPPLE_AMP0 + r_prod[28:14];
                    r_base <= RIPPLE_BASE;
                end
            end
            ST_INNER: r_x2   <= r_prod[30:15];
            ST_SUM:   r_gain <= gain;
            ST_MG:    r_red  <= chan_sat;
            ST_MB:    r_green <= chan_sat;
            default: begin
            end
        endcase
        if (r_state == ST_OUT && out_free) begin
            r_idx_o    <= r_job.index;
            r_red_o    <= off ? 8'd0 : r_red;
            r_green_o  <= off ? 8'd0 : r_green;
            r_blue_o   <= off ? 8'd0 : chan_sat;
            r_bright_o <= off ? 8'd0 : r_job.brightness;
        end
    end

    assign o_valid           = r_valid;
    assign o_pixel_out_index = r_idx_o;
    assign o_out_red         = r_red_o;
    assign o_out_green       = r_green_o;
    assign o_out_blue        = r_blue_o;
    assign o_out_brightness  = r_bright_o;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE)
        else $error("job taken while busy");

    a_off_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free && off) |=>
            (o_out_red == 8'd0 && o_out_green == 8'd0 && o_out_blue == 8'd0
             && o_out_brightness == 8'd0))
        else $error("off mode gave a colour");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !out_free) |=> r_state == ST_OUT)
        else $error("result left while output register full");

endmodule

// File: rtl/led_strip_effect_pixel_shader.sv
// Top level of the LED strip effect pixel shader: configuration registers,
// front end, job queue and back end. Depends on lsps_pkg and the lsps_* modules.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one pixel request per beat: index,
//   frame start flag, phase, motion energy, base colour and brightness.
//   Output channel (o_valid / i_ready) gives one shaded colour per request,
//   in request order.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
//   once; write them only while no pixel is in flight.
// Processing:
//   The front end classifies a request in its accept cycle and queues it.
//   The back end runs one shared multiplier through amplitude (ripple only),
//   sine polynomial, gain and three channel products, and takes the next
//   pixel from the queue only once the current one has left for the output
//   register; off mode goes straight to the output.
// Reset:
//   Mode returns to off, limits to 255, breath angle to zero, queue empties.
// Stall:
//   A result holds in the output register; the back end finishes the next
//   pixel and waits, while the queue keeps taking requests until full.
module led_strip_effect_pixel_shader
    import lsps_pkg::*;
#(
    parameter int LED_COUNT       = 256,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_index,
    input  logic        i_frame_start,
    input  logic [15:0] i_phase_angle,
    input  logic [9:0]  i_motion_energy,
    input  logic [7:0]  i_base_red,
    input  logic [7:0]  i_base_green,
    input  logic [7:0]  i_base_blue,
    input  logic [7:0]  i_brightness_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixel_out_index,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_brightness
);

    logic [1:0] r_effect_mode;
    t_limits    r_limits;
    logic       q_space;
    logic       q_avail;
    logic       push;
    logic       pop;
    t_job       front_job;
    t_job       back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode  <= MODE_OFF;
            r_limits.red   <= 8'd255;
            r_limits.green <= 8'd255;
            r_limits.blue  <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EFFECT_MODE: r_effect_mode  <= i_cfg_data[1:0];
                REG_MAX_RED:     r_limits.red   <= i_cfg_data;
                REG_MAX_GREEN:   r_limits.green <= i_cfg_data;
                REG_MAX_BLUE:    r_limits.blue  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lsps_front #(
        .LED_COUNT       (LED_COUNT),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (r_effect_mode),
        .i_pixel_index   (i_pixel_index),
        .i_frame_start   (i_frame_start),
        .i_phase_angle   (i_phase_angle),
        .i_motion_energy (i_motion_energy),
        .i_base_red      (i_base_red),
        .i_base_green    (i_base_green),
        .i_base_blue     (i_base_blue),
        .i_brightness_in (i_brightness_in),
        .i_space         (q_space),
        .o_push          (push),
        .o_job           (front_job)
    );

    lsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_space (q_space),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_job   (back_job)
    );

    lsps_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_avail           (q_avail),
        .i_job             (back_job),
        .o_pop             (pop),
        .i_limits          (r_limits),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pixel_out_index (o_pixel_out_index),
        .o_out_red         (o_out_red),
        .o_out_green       (o_out_green),
        .o_out_blue        (o_out_blue),
        .o_out_brightness  (o_out_brightness)
    );

endmodule
